// ----- design/tcp_stream_reassembler_unit_macros.svh -----
// Assertion macros shared by the reassembler RTL.
`ifndef TCP_STREAM_REASSEMBLER_UNIT_MACROS_SVH
`define TCP_STREAM_REASSEMBLER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked only out of reset.
`define TSR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsr assertion failed");
// Next-cycle implication, checked only out of reset.
`define TSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsr assertion failed");
`else
`define TSR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TSR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/tsr_pkg.sv -----
package tsr_pkg;

    localparam int BYTE_W = 8;
    localparam int IDX_W  = 32;
    localparam int CNT_W  = 7;

    // Input stream packing.
    localparam int IN_TDATA_W    = 40;
    localparam int IN_TUSER_W    = 2;
    localparam int IN_IDX_LSB    = 8;
    localparam int IN_USER_VALID = 0;
    localparam int IN_USER_EOF   = 1;

    // Output stream packing.
    localparam int OUT_TDATA_W    = 16;
    localparam int OUT_TUSER_W    = 2;
    localparam int OUT_PEND_LSB   = 8;
    localparam int OUT_USER_VALID = 0;
    localparam int OUT_USER_DONE  = 1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RELEASE
    } tsr_state_t;

    // Admission decision for one accepted item.
    typedef struct packed {
        logic             write_en;
        logic             set_end;
        logic [IDX_W-1:0] end_value;
    } tsr_admit_t;

    // Status carried beside the byte in the output stage.
    typedef struct packed {
        logic             byte_ok;
        logic             done;
        logic             last;
        logic [CNT_W-1:0] pend;
    } tsr_result_t;

endpackage

// ----- design/tcp_stream_reassembler_unit.sv -----
// An item is accepted only while idle; the next item waits until all of its results,
// 1 to CAPACITY of them, are loaded into the output stage. Released bytes leave at one
// per cycle while m_tready holds, with one read of the byte memory for each.
// Reset: present bits, head, pending count and end index clear at once; the byte
// memory is not reset and needs no clearing pass, as a slot is read only when present.
`include "tcp_stream_reassembler_unit_macros.svh"

module tcp_stream_reassembler_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input items.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata, lowest bit up: byte_value[7:0], stream_index[39:8].
    input  logic [tsr_pkg::IN_TDATA_W-1:0]   s_tdata,
    // s_tuser, lowest bit up: byte_valid[0], eof[1].
    input  logic [tsr_pkg::IN_TUSER_W-1:0]   s_tuser,
    // s_tlast carries segment_end.
    input  logic                             s_tlast,
    // Result items.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata, lowest bit up: out_byte[7:0], pending_bytes[14:8], zero[15].
    output logic [tsr_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // m_tuser, lowest bit up: out_valid[0], stream_done[1].
    output logic [tsr_pkg::OUT_TUSER_W-1:0]  m_tuser,
    // m_tlast carries last: the final result caused by one input item.
    output logic                             m_tlast
);

    // Width of a ring slot pointer; a single-entry ring still needs one bit.
    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // Control and window state. The byte data itself lives in the ring memory;
    // the present bits stay in flip-flops so reset clears them.
    tsr_pkg::tsr_state_t            state_reg, state_next;
    logic [CAPACITY-1:0]            present_reg, present_next;
    logic [tsr_pkg::IDX_W-1:0]      head_pos_reg, head_pos_next;
    logic [SW-1:0]                  head_slot_reg, head_slot_next;
    logic [tsr_pkg::CNT_W-1:0]      count_reg, count_next;
    logic                           end_known_reg, end_known_next;
    logic [tsr_pkg::IDX_W-1:0]      end_pos_reg, end_pos_next;

    // Output stage: the ring's read register holds the byte, these the status.
    logic                           out_vld_reg, out_vld_next;
    tsr_pkg::tsr_result_t           result_reg, result_next;

    logic                           accept;
    logic                           stage_free;
    logic                           issue;
    logic                           hit;
    logic                           last_byte;
    logic [SW-1:0]                  next_slot;
    logic [SW:0]                    slot_inc;
    logic [tsr_pkg::IDX_W-1:0]      head_inc;
    logic [tsr_pkg::CNT_W-1:0]      count_dec;
    logic [SW-1:0]                  ins_slot;
    tsr_pkg::tsr_admit_t            admit;
    logic [tsr_pkg::BYTE_W-1:0]     rd_data;

    // ------------------------------------------------------------------
    // Admission: window check, duplicate check, ring slot and end index.
    // ------------------------------------------------------------------
    tsr_admit #(
        .CAPACITY (CAPACITY),
        .SW       (SW)
    ) u_admit (
        .byte_valid    (s_tuser[tsr_pkg::IN_USER_VALID]),
        .stream_index  (s_tdata[tsr_pkg::IN_IDX_LSB +: tsr_pkg::IDX_W]),
        .segment_end   (s_tlast),
        .eof           (s_tuser[tsr_pkg::IN_USER_EOF]),
        .head_position (head_pos_reg),
        .head_slot     (head_slot_reg),
        .end_known     (end_known_reg),
        .end_position  (end_pos_reg),
        .present       (present_reg),
        .slot          (ins_slot),
        .admit         (admit)
    );

    // ------------------------------------------------------------------
    // Byte ring. Writes happen only in the accept cycle and reads only while
    // releasing, so the state machine itself keeps the two ports from ever
    // touching the same entry in one cycle.
    // ------------------------------------------------------------------
    tsr_ring #(
        .DEPTH (CAPACITY),
        .AW    (SW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (accept && admit.write_en),
        .wr_addr (ins_slot),
        .wr_data (s_tdata[tsr_pkg::BYTE_W-1:0]),
        .rd_en   (issue && hit),
        .rd_addr (head_slot_reg),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Head-of-window view used while releasing.
    // ------------------------------------------------------------------
    always_comb
    begin
        slot_inc  = {1'b0, head_slot_reg} + (SW+1)'(1);
        next_slot = (slot_inc == (SW+1)'(CAPACITY)) ? '0 : slot_inc[SW-1:0];
        hit       = present_reg[head_slot_reg];
        // The run ends when the following slot is empty; with a one-entry ring
        // the following slot is the one being released.
        last_byte = !present_reg[next_slot] || (next_slot == head_slot_reg);
        head_inc  = head_pos_reg + tsr_pkg::IDX_W'(1);
        count_dec = (count_reg == '0) ? '0 : count_reg - tsr_pkg::CNT_W'(1);
    end

    // ------------------------------------------------------------------
    // Next-state logic.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tsr_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = tsr_pkg::ST_RELEASE;
                end
            end
            tsr_pkg::ST_RELEASE:
            begin
                // A status-only result or the final byte of the run ends the item.
                if (stage_free && (!hit || last_byte))
                begin
                    state_next = tsr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tsr_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output and datapath control.
    // ------------------------------------------------------------------
    always_comb
    begin
        s_tready   = (state_reg == tsr_pkg::ST_IDLE);
        accept     = s_tvalid && s_tready;
        stage_free = !out_vld_reg || m_tready;
        issue      = (state_reg == tsr_pkg::ST_RELEASE) && stage_free;

        present_next   = present_reg;
        head_pos_next  = head_pos_reg;
        head_slot_next = head_slot_reg;
        count_next     = count_reg;
        end_known_next = end_known_reg;
        end_pos_next   = end_pos_reg;
        out_vld_next   = out_vld_reg && !m_tready;
        result_next    = result_reg;

        if (accept)
        begin
            if (admit.write_en)
            begin
                present_next[ins_slot] = 1'b1;
                count_next             = count_reg + tsr_pkg::CNT_W'(1);
            end
            if (admit.set_end)
            begin
                end_known_next = 1'b1;
                end_pos_next   = admit.end_value;
            end
        end

        if (issue)
        begin
            out_vld_next = 1'b1;
            if (hit)
            begin
                // Release the head byte; status reflects the state after it.
                present_next[head_slot_reg] = 1'b0;
                head_pos_next       = head_inc;
                head_slot_next      = next_slot;
                count_next          = count_dec;
                result_next.byte_ok = 1'b1;
                result_next.done    = end_known_reg && (head_inc == end_pos_reg);
                result_next.last    = last_byte;
                result_next.pend    = count_dec;
            end
            else
            begin
                // Nothing to release: one status-only result.
                result_next.byte_ok = 1'b0;
                result_next.done    = end_known_reg && (head_pos_reg == end_pos_reg);
                result_next.last    = 1'b1;
                result_next.pend    = count_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tsr_pkg::ST_IDLE;
            present_reg   <= '0;
            head_pos_reg  <= '0;
            head_slot_reg <= '0;
            count_reg     <= '0;
            end_known_reg <= 1'b0;
            end_pos_reg   <= '0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            present_reg   <= present_next;
            head_pos_reg  <= head_pos_next;
            head_slot_reg <= head_slot_next;
            count_reg     <= count_next;
            end_known_reg <= end_known_next;
            end_pos_reg   <= end_pos_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    // Result status is payload and needs no reset.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // ------------------------------------------------------------------
    // Result port. A status-only result shows a zero byte.
    // ------------------------------------------------------------------
    always_comb
    begin
        m_tvalid = out_vld_reg;
        m_tdata  = {1'b0, result_reg.pend,
                    result_reg.byte_ok ? rd_data : tsr_pkg::BYTE_W'(0)};
        m_tuser  = {result_reg.done, result_reg.byte_ok};
        m_tlast  = result_reg.last;
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // The pending count always matches the number of occupied ring slots.
    `TSR_ASSERT_IMP(a_count_matches_present, clk, rst_n, 1'b1,
        $countones(present_reg) == int'(count_reg))
    // A byte released from the ring shows up as a valid byte result next cycle.
    `TSR_ASSERT_NEXT(a_release_reaches_port, clk, rst_n, issue && hit,
        m_tvalid && m_tuser[tsr_pkg::OUT_USER_VALID])
    // Loading the final result of an item returns the block to accepting input.
    `TSR_ASSERT_NEXT(a_last_frees_input, clk, rst_n, issue && (!hit || last_byte),
        s_tready && m_tlast)

endmodule

// ----- design/tsr_ring.sv -----
module tsr_ring #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [tsr_pkg::BYTE_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [tsr_pkg::BYTE_W-1:0] rd_data
);

    logic [tsr_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [tsr_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // The read register holds its value while no read is issued, so it can
    // serve as the output stage of the block.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/tsr_admit.sv -----
module tsr_admit #(
    parameter int CAPACITY = 64,
    parameter int SW       = 6
) (
    input  logic                     byte_valid,
    input  logic [tsr_pkg::IDX_W-1:0] stream_index,
    input  logic                     segment_end,
    input  logic                     eof,
    input  logic [tsr_pkg::IDX_W-1:0] head_position,
    input  logic [SW-1:0]            head_slot,
    input  logic                     end_known,
    input  logic [tsr_pkg::IDX_W-1:0] end_position,
    input  logic [CAPACITY-1:0]      present,
    output logic [SW-1:0]            slot,
    output tsr_pkg::tsr_admit_t      admit
);

    logic [tsr_pkg::IDX_W-1:0] offset;
    logic [tsr_pkg::IDX_W-1:0] room;
    logic [tsr_pkg::IDX_W-1:0] cand;
    logic [tsr_pkg::IDX_W-1:0] cand_dist;
    logic [SW:0]               slot_sum;
    logic                      keep;

    always_comb
    begin
        offset = stream_index - head_position;
        room   = end_position - head_position;
        keep   = byte_valid && (offset < tsr_pkg::IDX_W'(CAPACITY))
                 && !(end_known && (offset >= room));

        // For a kept item both terms are below CAPACITY, so one subtract wraps the ring.
        slot_sum = {1'b0, head_slot} + {1'b0, offset[SW-1:0]};
        if (slot_sum >= (SW+1)'(CAPACITY))
        begin
            slot_sum = slot_sum - (SW+1)'(CAPACITY);
        end
        slot = slot_sum[SW-1:0];

        // An end index that lies behind the head collapses onto the head.
        cand      = stream_index + tsr_pkg::IDX_W'(byte_valid);
        cand_dist = cand - head_position;

        admit.write_en  = keep && !present[slot];
        admit.set_end   = segment_end && eof && !end_known;
        admit.end_value = cand_dist[tsr_pkg::IDX_W-1] ? head_position : cand;
    end

endmodule
